>>> rtl/rtp_pkg.sv
// shared types, constants and helpers of the rotation trapezoid profiler
package rtp_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STOP_WINDOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WHEEL_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ACCEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_BIAS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_PER_RPM   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RPM_LIMIT       = 3'd7;

  // register reset values
  localparam logic [15:0] RST_STOP_WINDOW     = 16'd2048;
  localparam logic [15:0] RST_HALF_WHEEL_BASE = 16'd5120;
  localparam logic [15:0] RST_DEFAULT_ACCEL   = 16'd1000;
  localparam logic [15:0] RST_CRUISE_SPEED    = 16'd200;
  localparam logic [23:0] RST_TICK_PERIOD     = 24'd16777;
  localparam logic [15:0] RST_WHEEL_BIAS      = 16'd0;
  localparam logic [23:0] RST_SPEED_PER_RPM   = 24'd65536;
  localparam logic [14:0] RST_RPM_LIMIT       = 15'd32767;

  // digit-serial multiplier geometry
  localparam int unsigned MUL_AW     = 33;
  localparam int unsigned MUL_BW     = 32;
  localparam int unsigned MUL_DGW    = 4;
  localparam int unsigned MUL_PW     = MUL_AW + MUL_BW;
  localparam int unsigned MUL_DIGITS = MUL_BW / MUL_DGW;
  localparam int unsigned MUL_CW     = $clog2(MUL_DIGITS + 1);

  // bit-serial divider geometry
  localparam int unsigned DIV_DW = 34;
  localparam int unsigned DIV_LW = 32;
  localparam int unsigned DIV_CW = 6;
  localparam logic [DIV_CW-1:0] DIV_BRK_STEPS = 6'd32;
  localparam logic [DIV_CW-1:0] DIV_RPM_STEPS = 6'd16;

  localparam logic [31:0] SPEED_MAX = 32'hFFFF_FFFF;

  // |rpm| * speed_per_rpm at or below this means 10 * x < 2^20
  localparam logic [MUL_PW-1:0] STOP_LIMIT = 65'd104857;

  typedef struct packed {
    logic [15:0] stop_window;
    logic [15:0] half_wheel_base;
    logic [15:0] default_accel;
    logic [15:0] cruise_speed;
    logic [23:0] tick_period;
    logic [15:0] wheel_bias;
    logic [23:0] speed_per_rpm;
    logic [14:0] rpm_limit;
  } cfg_t;

  typedef struct packed {
    logic              go;
    logic [MUL_AW-1:0] a;
    logic [MUL_BW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [MUL_PW-1:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic              go;
    logic [DIV_DW-1:0] hi;
    logic [DIV_LW-1:0] lo;
    logic [DIV_DW-1:0] d;
    logic [DIV_CW-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_LW-1:0] q;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_STOPL,
    S_STOPR,
    S_CS,
    S_DX,
    S_SQ,
    S_BRK,
    S_SEL,
    S_DBRK,
    S_DACC,
    S_BL,
    S_DL,
    S_BR,
    S_DR,
    S_EMIT
  } state_t;

  // magnitude of a 16-bit two's complement value
  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? (16'd0 - v) : v;
  endfunction

endpackage

>>> rtl/rtp_regs.sv
// configuration register file of the rotation trapezoid profiler
module rtp_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]  wr_idx,
  input  logic [rtp_pkg::CFG_DATA_W-1:0] wr_data,
  output rtp_pkg::cfg_t                  cfg
);

  rtp_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stop_window     <= rtp_pkg::RST_STOP_WINDOW;
      cfg_r.half_wheel_base <= rtp_pkg::RST_HALF_WHEEL_BASE;
      cfg_r.default_accel   <= rtp_pkg::RST_DEFAULT_ACCEL;
      cfg_r.cruise_speed    <= rtp_pkg::RST_CRUISE_SPEED;
      cfg_r.tick_period     <= rtp_pkg::RST_TICK_PERIOD;
      cfg_r.wheel_bias      <= rtp_pkg::RST_WHEEL_BIAS;
      cfg_r.speed_per_rpm   <= rtp_pkg::RST_SPEED_PER_RPM;
      cfg_r.rpm_limit       <= rtp_pkg::RST_RPM_LIMIT;
    end else if (wr_en) begin
      unique case (wr_idx)
        rtp_pkg::REG_STOP_WINDOW:     cfg_r.stop_window     <= wr_data[15:0];
        rtp_pkg::REG_HALF_WHEEL_BASE: cfg_r.half_wheel_base <= wr_data[15:0];
        rtp_pkg::REG_DEFAULT_ACCEL:   cfg_r.default_accel   <= wr_data[15:0];
        rtp_pkg::REG_CRUISE_SPEED:    cfg_r.cruise_speed    <= wr_data[15:0];
        rtp_pkg::REG_TICK_PERIOD:     cfg_r.tick_period     <= wr_data[23:0];
        rtp_pkg::REG_WHEEL_BIAS:      cfg_r.wheel_bias      <= wr_data[15:0];
        rtp_pkg::REG_SPEED_PER_RPM:   cfg_r.speed_per_rpm   <= wr_data[23:0];
        rtp_pkg::REG_RPM_LIMIT:       cfg_r.rpm_limit       <= wr_data[14:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/rtp_mul.sv
// digit-serial multiplier, one 4-bit digit of the b operand per cycle
module rtp_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  rtp_pkg::mul_req_t req,
  output rtp_pkg::mul_rsp_t rsp
);

  localparam int unsigned SW = rtp_pkg::MUL_AW + rtp_pkg::MUL_DGW;

  logic [rtp_pkg::MUL_PW-1:0] p_r;
  logic [rtp_pkg::MUL_AW-1:0] a_r;
  logic [rtp_pkg::MUL_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [SW-1:0]              sum;

  // partial product of the low digit added to the upper half
  assign sum = SW'(p_r[rtp_pkg::MUL_PW-1:rtp_pkg::MUL_BW])
             + SW'(a_r) * SW'(p_r[rtp_pkg::MUL_DGW-1:0]);

  always_ff @(posedge clk) begin
    if (req.go) begin
      a_r <= req.a;
      p_r <= {{rtp_pkg::MUL_AW{1'b0}}, req.b};
    end else if (busy_r) begin
      p_r <= {sum, p_r[rtp_pkg::MUL_BW-1:rtp_pkg::MUL_DGW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= rtp_pkg::MUL_CW'(rtp_pkg::MUL_DIGITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rtp_pkg::MUL_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

endmodule

>>> rtl/rtp_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module rtp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rtp_pkg::div_req_t req,
  output rtp_pkg::div_rsp_t rsp
);

  localparam int unsigned DW = rtp_pkg::DIV_DW;
  localparam int unsigned LW = rtp_pkg::DIV_LW;

  logic [DW-1:0]              r_r;
  logic [DW-1:0]              d_r;
  logic [LW-1:0]              l_r;
  logic [LW-1:0]              q_r;
  logic [rtp_pkg::DIV_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [DW:0]                t;
  logic [DW+1:0]              diff;
  logic                       ge;

  // partial remainder stays below the divisor, so one trial subtract a bit
  assign t    = {r_r, l_r[LW-1]};
  assign diff = {1'b0, t} - {2'b00, d_r};
  assign ge   = !diff[DW+1];

  always_ff @(posedge clk) begin
    if (req.go) begin
      r_r <= req.hi;
      l_r <= req.lo;
      d_r <= req.d;
      q_r <= '0;
    end else if (busy_r) begin
      r_r <= ge ? diff[DW-1:0] : t[DW-1:0];
      l_r <= {l_r[LW-2:0], 1'b0};
      q_r <= {q_r[LW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == rtp_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.q    = q_r;

endmodule

>>> rtl/rotation_trapezoid_profiler.sv
// top level of the rotation trapezoid profiler: sequencer and datapath
// Speed setpoint generator for turning a two-wheel drive in place. A start item (tuser 0)
// latches target heading = heading + turn_angle and returns an all-zero result. A tick item
// (tuser 1) compares the target with the measured heading: inside the stop window it commands
// zero and flags turn_done once both measured wheels are below 0.1 mm/s; outside it ramps the
// present speed toward the cruise speed, or brakes at v^2/(2*arc) when that exceeds the
// default deceleration, applies the wheel bias, converts to Q11.4 RPM, clamps to rpm_limit
// and drives the two wheels in opposite directions. Every item gives exactly one result.
// One item is worked on at a time; the result register lets the next item in while the
// last result still waits. A moving tick runs up to six products on the one shared
// multiplier (one 4-bit digit per cycle) and its divisions on the shared bit-serial
// divider (one quotient bit per cycle: 32 bits for the braking term, 16 per wheel for
// the RPM conversion).
module rotation_trapezoid_profiler (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // heading[23:0], turn_angle[47:24], measured_left_rpm[63:48],
  // measured_right_rpm[79:64], current_left_setpoint[95:80]
  input  logic [rtp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op[0]
  input  logic                            in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // left_command[15:0], right_command[31:16]
  output logic [rtp_pkg::OUT_TDATA_W-1:0] out_tdata,
  // command_valid[0], turn_done[1]
  output logic [rtp_pkg::OUT_TUSER_W-1:0] out_tuser,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rtp_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rtp_pkg::cfg_t     cfg;
  rtp_pkg::mul_req_t mul_req;
  rtp_pkg::mul_rsp_t mul_rsp;
  rtp_pkg::div_req_t div_req;
  rtp_pkg::div_rsp_t div_rsp;
  rtp_pkg::state_t   state_r, state_nxt;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  rtp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  rtp_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  rtp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // latched input item
  logic        op_r;
  logic [23:0] head_r;
  logic [23:0] turn_r;
  logic [15:0] mlr_r;
  logic [15:0] mrr_r;
  logic [15:0] cls_r;

  // turn state
  logic [23:0] tgt_r;
  logic        tpos_r;

  // working values of a tick
  logic [24:0] aerr_r;
  logic        stop_l_r;
  logic [31:0] cs_r;
  logic [33:0] d2_r;
  logic [31:0] brk_r;
  logic [32:0] spd_mag_r;
  logic        spd_neg_r;
  logic [33:0] mag_r;
  logic [14:0] rl_r;
  logic        pend_r;

  // pending result and output register
  logic [15:0] res_left_r;
  logic [15:0] res_right_r;
  logic [1:0]  res_user_r;
  logic        out_tvalid_r;
  logic [rtp_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic [rtp_pkg::OUT_TUSER_W-1:0] out_tuser_r;

  logic        in_xfer;
  logic        emit_ok;
  logic        mul_fin;
  logic        div_fin;

  logic [24:0] err;
  logic [24:0] aerr;
  logic        epos;
  logic        in_window;
  logic        stopped;
  logic [31:0] cs_val;
  logic        brk_sat;
  logic [31:0] brk_val;
  logic [31:0] acc16;
  logic [31:0] cru16;
  logic [33:0] brk_diff;
  logic [33:0] brk_mag;
  logic [32:0] acc_sum;
  logic [15:0] bias16;
  logic [16:0] fact_l;
  logic [16:0] fact_r;
  logic [21:0] rpm_hi;
  logic        rpm_zero;
  logic        rpm_sat;
  logic        rpm_skip;
  logic [15:0] rpm_q;
  logic [14:0] rpm_div;
  logic [14:0] rpm_val;
  logic        lneg;
  logic        rneg;
  logic [15:0] left_cmd;
  logic [15:0] right_cmd;

  assign in_xfer = in_tvalid && in_tready;
  assign emit_ok = !out_tvalid_r || out_tready;
  assign mul_fin = pend_r && mul_rsp.done;
  assign div_fin = pend_r && div_rsp.done;

  // heading error and stop window
  assign err       = {tgt_r[23], tgt_r} - {head_r[23], head_r};
  assign aerr      = err[24] ? (25'd0 - err) : err;
  assign epos      = !err[24] && (err != 25'd0);
  assign in_window = aerr <= {9'd0, cfg.stop_window};

  // wheel stopped test on |rpm| * speed_per_rpm
  assign stopped = mul_rsp.p <= rtp_pkg::STOP_LIMIT;

  // present speed in Q16.16, saturated
  assign cs_val = (|mul_rsp.p[rtp_pkg::MUL_PW-1:36]) ? rtp_pkg::SPEED_MAX : mul_rsp.p[35:4];

  // braking term: quotient beyond 32 bits saturates, zero arc lands here too
  assign brk_sat = {2'b00, mul_rsp.p[63:32]} >= d2_r;
  assign brk_val = brk_sat ? rtp_pkg::SPEED_MAX : div_rsp.q;

  assign acc16 = {cfg.default_accel, 16'd0};
  assign cru16 = {cfg.cruise_speed, 16'd0};

  // speed after braking may go negative (wheels reverse)
  assign brk_diff = {2'b00, cs_r} - {2'b00, mul_rsp.p[55:24]};
  assign brk_mag  = brk_diff[33] ? (34'd0 - brk_diff) : brk_diff;
  assign acc_sum  = {1'b0, cs_r} + {1'b0, mul_rsp.p[39:8]};

  // bias factors 1 - b and 1 + b in Q.15
  assign bias16 = {~cfg.wheel_bias[15], cfg.wheel_bias[14:0]};
  assign fact_l = 17'h10000 - {1'b0, bias16};
  assign fact_r = {1'b0, bias16};

  // rpm conversion: (mag << 4) / speed_per_rpm, clamped
  assign rpm_hi   = mag_r[33:12];
  assign rpm_zero = mag_r == 34'd0;
  assign rpm_sat  = {2'b00, rpm_hi} >= cfg.speed_per_rpm;
  assign rpm_skip = rpm_zero || rpm_sat;
  assign rpm_q    = div_rsp.q[15:0];
  assign rpm_div  = (rpm_q > {1'b0, cfg.rpm_limit}) ? cfg.rpm_limit : rpm_q[14:0];
  assign rpm_val  = rpm_zero ? 15'd0 : (rpm_sat ? cfg.rpm_limit : rpm_div);

  // direction: the wheel on the turn side runs backward
  assign lneg      = spd_neg_r ^ tpos_r;
  assign rneg      = spd_neg_r ^ !tpos_r;
  assign left_cmd  = lneg ? (16'd0 - {1'b0, rl_r}) : {1'b0, rl_r};
  assign right_cmd = rneg ? (16'd0 - {1'b0, rpm_val}) : {1'b0, rpm_val};

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rtp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtp_pkg::S_IDLE: begin
        if (in_xfer) state_nxt = rtp_pkg::S_ERR;
      end
      rtp_pkg::S_ERR: begin
        if (!op_r) state_nxt = rtp_pkg::S_EMIT;
        else if (in_window) state_nxt = rtp_pkg::S_STOPL;
        else state_nxt = rtp_pkg::S_CS;
      end
      rtp_pkg::S_STOPL: begin
        if (mul_fin) state_nxt = rtp_pkg::S_STOPR;
      end
      rtp_pkg::S_STOPR: begin
        if (mul_fin) state_nxt = rtp_pkg::S_EMIT;
      end
      rtp_pkg::S_CS: begin
        if (mul_fin) state_nxt = rtp_pkg::S_DX;
      end
      rtp_pkg::S_DX: begin
        if (mul_fin) state_nxt = rtp_pkg::S_SQ;
      end
      rtp_pkg::S_SQ: begin
        if (!pend_r && cs_r == 32'd0) state_nxt = rtp_pkg::S_SEL;
        else if (mul_fin) state_nxt = rtp_pkg::S_BRK;
      end
      rtp_pkg::S_BRK: begin
        if ((!pend_r && brk_sat) || div_fin) state_nxt = rtp_pkg::S_SEL;
      end
      rtp_pkg::S_SEL: begin
        if (brk_r > acc16) state_nxt = rtp_pkg::S_DBRK;
        else if (cs_r < cru16) state_nxt = rtp_pkg::S_DACC;
        else state_nxt = rtp_pkg::S_BL;
      end
      rtp_pkg::S_DBRK: begin
        if (mul_fin) state_nxt = rtp_pkg::S_BL;
      end
      rtp_pkg::S_DACC: begin
        if (mul_fin) state_nxt = rtp_pkg::S_BL;
      end
      rtp_pkg::S_BL: begin
        if (mul_fin) state_nxt = rtp_pkg::S_DL;
      end
      rtp_pkg::S_DL: begin
        if ((!pend_r && rpm_skip) || div_fin) state_nxt = rtp_pkg::S_BR;
      end
      rtp_pkg::S_BR: begin
        if (mul_fin) state_nxt = rtp_pkg::S_DR;
      end
      rtp_pkg::S_DR: begin
        if ((!pend_r && rpm_skip) || div_fin) state_nxt = rtp_pkg::S_EMIT;
      end
      rtp_pkg::S_EMIT: begin
        if (emit_ok) state_nxt = rtp_pkg::S_IDLE;
      end
      default: state_nxt = rtp_pkg::S_IDLE;
    endcase
  end

  // unit requests and handshake outputs
  always_comb begin
    in_tready     = state_r == rtp_pkg::S_IDLE;
    mul_req       = '0;
    div_req       = '0;
    unique case (state_r) inside
      rtp_pkg::S_STOPL: begin
        mul_req.go = !pend_r;
        mul_req.a  = rtp_pkg::MUL_AW'(rtp_pkg::abs16(mlr_r));
        mul_req.b  = rtp_pkg::MUL_BW'(cfg.speed_per_rpm);
      end
      rtp_pkg::S_STOPR: begin
        mul_req.go = !pend_r;
        mul_req.a  = rtp_pkg::MUL_AW'(rtp_pkg::abs16(mrr_r));
        mul_req.b  = rtp_pkg::MUL_BW'(cfg.speed_per_rpm);
      end
      rtp_pkg::S_CS: begin
        mul_req.go = !pend_r;
        mul_req.a  = rtp_pkg::MUL_AW'(rtp_pkg::abs16(cls_r));
        mul_req.b  = rtp_pkg::MUL_BW'(cfg.speed_per_rpm);
      end
      rtp_pkg::S_DX: begin
        mul_req.go = !pend_r;
        mul_req.a  = rtp_pkg::MUL_AW'(aerr_r);
        mul_req.b  = rtp_pkg::MUL_BW'(cfg.half_wheel_base);
      end
      rtp_pkg::S_SQ: begin
        mul_req.go = !pend_r && (cs_r != 32'd0);
        mul_req.a  = rtp_pkg::MUL_AW'(cs_r);
        mul_req.b  = cs_r;
      end
      rtp_pkg::S_BRK: begin
        div_req.go    = !pend_r && !brk_sat;
        div_req.hi    = {2'b00, mul_rsp.p[63:32]};
        div_req.lo    = mul_rsp.p[31:0];
        div_req.d     = d2_r;
        div_req.steps = rtp_pkg::DIV_BRK_STEPS;
      end
      rtp_pkg::S_DBRK: begin
        mul_req.go = !pend_r;
        mul_req.a  = rtp_pkg::MUL_AW'(brk_r);
        mul_req.b  = rtp_pkg::MUL_BW'(cfg.tick_period);
      end
      rtp_pkg::S_DACC: begin
        mul_req.go = !pend_r;
        mul_req.a  = rtp_pkg::MUL_AW'(cfg.default_accel);
        mul_req.b  = rtp_pkg::MUL_BW'(cfg.tick_period);
      end
      rtp_pkg::S_BL: begin
        mul_req.go = !pend_r;
        mul_req.a  = spd_mag_r;
        mul_req.b  = rtp_pkg::MUL_BW'(fact_l);
      end
      rtp_pkg::S_BR: begin
        mul_req.go = !pend_r;
        mul_req.a  = spd_mag_r;
        mul_req.b  = rtp_pkg::MUL_BW'(fact_r);
      end
      rtp_pkg::S_DL, rtp_pkg::S_DR: begin
        div_req.go    = !pend_r && !rpm_skip;
        div_req.hi    = rtp_pkg::DIV_DW'(rpm_hi);
        div_req.lo    = {mag_r[11:0], 4'd0, 16'd0};
        div_req.d     = rtp_pkg::DIV_DW'(cfg.speed_per_rpm);
        div_req.steps = rtp_pkg::DIV_RPM_STEPS;
      end
      default: ;
    endcase
  end

  // input item capture
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r   <= in_tuser;
      head_r <= in_tdata[23:0];
      turn_r <= in_tdata[47:24];
      mlr_r  <= in_tdata[63:48];
      mrr_r  <= in_tdata[79:64];
      cls_r  <= in_tdata[95:80];
    end
  end

  // turn state, unit bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r        <= 24'd0;
      tpos_r       <= 1'b0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == rtp_pkg::S_ERR) begin
        if (!op_r) begin
          tgt_r  <= head_r + turn_r;
          tpos_r <= !turn_r[23] && (turn_r != 24'd0);
        end else if (!in_window) begin
          tpos_r <= epos;
        end
      end
      if (mul_req.go || div_req.go) pend_r <= 1'b1;
      else if (mul_fin || div_fin) pend_r <= 1'b0;
      if (state_r == rtp_pkg::S_EMIT && emit_ok) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;
    end
  end

  // tick datapath
  always_ff @(posedge clk) begin
    unique case (state_r) inside
      rtp_pkg::S_ERR: begin
        aerr_r <= aerr;
        if (!op_r) begin
          res_left_r  <= 16'd0;
          res_right_r <= 16'd0;
          res_user_r  <= 2'b00;
        end
      end
      rtp_pkg::S_STOPL: begin
        if (mul_fin) stop_l_r <= stopped;
      end
      rtp_pkg::S_STOPR: begin
        if (mul_fin) begin
          res_left_r  <= 16'd0;
          res_right_r <= 16'd0;
          res_user_r  <= {stop_l_r && stopped, 1'b1};
        end
      end
      rtp_pkg::S_CS: begin
        if (mul_fin) cs_r <= cs_val;
      end
      rtp_pkg::S_DX: begin
        if (mul_fin) d2_r <= {mul_rsp.p[40:8], 1'b0};
      end
      rtp_pkg::S_SQ: begin
        if (!pend_r && cs_r == 32'd0) brk_r <= 32'd0;
      end
      rtp_pkg::S_BRK: begin
        if ((!pend_r && brk_sat) || div_fin) brk_r <= brk_val;
      end
      rtp_pkg::S_SEL: begin
        // cruising: speed held
        spd_mag_r <= {1'b0, cs_r};
        spd_neg_r <= 1'b0;
      end
      rtp_pkg::S_DBRK: begin
        if (mul_fin) begin
          spd_mag_r <= brk_mag[32:0];
          spd_neg_r <= brk_diff[33];
        end
      end
      rtp_pkg::S_DACC: begin
        if (mul_fin) begin
          spd_mag_r <= acc_sum;
          spd_neg_r <= 1'b0;
        end
      end
      rtp_pkg::S_BL, rtp_pkg::S_BR: begin
        if (mul_fin) mag_r <= mul_rsp.p[48:15];
      end
      rtp_pkg::S_DL: begin
        if ((!pend_r && rpm_skip) || div_fin) rl_r <= rpm_val;
      end
      rtp_pkg::S_DR: begin
        if ((!pend_r && rpm_skip) || div_fin) begin
          res_left_r  <= left_cmd;
          res_right_r <= right_cmd;
          res_user_r  <= 2'b01;
        end
      end
      rtp_pkg::S_EMIT: begin
        if (emit_ok) begin
          out_tdata_r <= {res_right_r, res_left_r};
          out_tuser_r <= res_user_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

>>> rtl/rtp_checker.sv
// port-level checker of the rotation trapezoid profiler and its bind
module rtp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rtp_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rtp_pkg::OUT_TUSER_W-1:0] out_tuser
);

  // one item at a time: no back-to-back input transfers
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in work");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // start results carry no command and no done flag
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0 && !out_tuser[1])
    else $error("start result not all zero");

  // done only comes with a zero command
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && out_tdata == '0)
    else $error("turn done with nonzero command");

endmodule

bind rotation_trapezoid_profiler rtp_checker u_chk (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the rotation trapezoid profiler: directed table, random turns
module testbench;
  import rtp_pkg::*;

  // item kinds on in_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // how a table row is checked: by the predictor, or by a result read off at a glance
  // (the typed results all carry zero commands, the value is {turn_done, command_valid})
  localparam int PREDICT     = -1;
  localparam int ZERO_RESULT = 0;
  localparam int HOLD_MOVING = 1;
  localparam int HOLD_DONE   = 3;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS  = 70;
  localparam int N_PHASES     = 9;

  // how a register value is chosen for a setting
  typedef enum {PICK_LOW, PICK_HIGH, PICK_ANY, PICK_TYPICAL, PICK_MIXED} pick_t;

  typedef struct packed {
    logic [15:0] left_cmd;
    logic [15:0] right_cmd;
    logic        cmd_valid;
    logic        turn_done;
  } wheel_cmd_t;

  typedef struct {
    logic                  op;
    logic [IN_TDATA_W-1:0] d;
    int                    known;
  } probe_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  rotation_trapezoid_profiler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of the registers and of the turn state
  cfg_t        model_cfg;
  logic [23:0] model_target   = '0;
  logic        model_positive = 1'b0;

  wheel_cmd_t  pending_cmds[$];   // commands still owed by the block, oldest first
  int          mismatches  = 0;
  int          quiet       = 0;
  int          burst_left  = 0;
  int          gap_max     = 4;
  logic [15:0] last_left   = '0;  // last predicted left command, fed back as setpoint

  // receiver stall pattern, rotated every cycle and reloaded whenever pat_step wraps
  logic [31:0] ready_pat  = '1;
  logic [4:0]  pat_step   = '0;
  logic        ready_lazy = 1'b1;

  function automatic logic [63:0] mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // signed Q.16 speed times a Q.15 factor, truncated toward zero
  function automatic longint biased(input longint spd, input logic [63:0] factor);
    logic [63:0] m;
    m = (mag(spd) * factor) >> 15;
    return (spd < 0) ? -longint'(m) : longint'(m);
  endfunction

  // signed Q.16 mm/s to signed Q11.4 rpm, magnitude clamped to rpm_limit
  function automatic longint speed_to_rpm(input longint spd);
    logic [63:0] m, r;
    m = mag(spd);
    if (model_cfg.speed_per_rpm == '0)
      r = (m != 0) ? 64'(model_cfg.rpm_limit) : 64'd0;
    else
      r = (m << 4) / 64'(model_cfg.speed_per_rpm);
    if (r > 64'(model_cfg.rpm_limit))
      r = 64'(model_cfg.rpm_limit);
    return (spd < 0) ? -longint'(r) : longint'(r);
  endfunction

  // below 0.1 mm/s, tested exactly in integers
  function automatic logic wheel_still(input logic [15:0] rpm);
    return 64'd10 * mag(longint'($signed(rpm))) * 64'(model_cfg.speed_per_rpm) < 64'd1048576;
  endfunction

  // next wheel command for one accepted item; updates the turn state
  function automatic wheel_cmd_t next_wheel_command(input logic op,
                                                    input logic [IN_TDATA_W-1:0] d);
    longint      hdg, trn, err, spd, lcmd, rcmd;
    logic [63:0] aerr, cs, dx, brk, delta, bias;
    wheel_cmd_t  res;
    res = '0;
    hdg = longint'($signed(d[23:0]));
    if (op == OP_START) begin
      trn = longint'($signed(d[47:24]));
      model_target = 24'(hdg + trn);
      model_positive = trn > 0;
      return res;
    end
    err = longint'($signed(model_target)) - hdg;
    aerr = mag(err);
    res.cmd_valid = 1'b1;
    // inside the stop window: zero command, done once both wheels are still
    if (aerr <= 64'(model_cfg.stop_window)) begin
      res.turn_done = wheel_still(d[63:48]) && wheel_still(d[79:64]);
      return res;
    end
    model_positive = err > 0;
    // present speed from the left setpoint, Q16.16 saturated
    cs = (mag(longint'($signed(d[95:80]))) * 64'(model_cfg.speed_per_rpm)) >> 4;
    if (cs > 64'(SPEED_MAX))
      cs = 64'(SPEED_MAX);
    // remaining arc and the deceleration needed to stop on it
    dx = (aerr * 64'(model_cfg.half_wheel_base)) >> 8;
    if (cs == 0)
      brk = 64'd0;
    else if (dx == 0)
      brk = 64'(SPEED_MAX);
    else begin
      brk = (cs * cs) / (dx << 1);
      if (brk > 64'(SPEED_MAX))
        brk = 64'(SPEED_MAX);
    end
    if (brk > (64'(model_cfg.default_accel) << 16)) begin
      delta = (brk * 64'(model_cfg.tick_period)) >> 24;
      spd = longint'(cs) - longint'(delta);
    end else if (cs < (64'(model_cfg.cruise_speed) << 16)) begin
      delta = (64'(model_cfg.default_accel) * 64'(model_cfg.tick_period)) >> 8;
      spd = longint'(cs) + longint'(delta);
    end else begin
      spd = longint'(cs);
    end
    bias = 64'(32768 + longint'($signed(model_cfg.wheel_bias)));
    lcmd = speed_to_rpm(biased(spd, 64'd65536 - bias));
    rcmd = speed_to_rpm(biased(spd, bias));
    if (model_positive)
      lcmd = -lcmd;
    else
      rcmd = -rcmd;
    res.left_cmd = 16'(lcmd);
    res.right_cmd = 16'(rcmd);
    return res;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_in(input logic [23:0] hdg, turn,
                                                    input logic [15:0] ml, mr, sp);
    return {sp, mr, ml, turn, hdg};
  endfunction

  function automatic probe_t probe(input logic op, input int hdg, turn, ml, mr, sp, known);
    probe_t p;
    p.op = op;
    p.d = pack_in(24'(hdg), 24'(turn), 16'(ml), 16'(mr), 16'(sp));
    p.known = known;
    return p;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_IDX_W-1:0] idx,
                                                       input pick_t how);
    int lo, hi, tlo, thi, v;
    // full range, then a span around what a real drive would use
    case (idx)
      REG_STOP_WINDOW:     begin lo = 0;      hi = 65535;    tlo = 256;   thi = 8192;   end
      REG_HALF_WHEEL_BASE: begin lo = 0;      hi = 65535;    tlo = 1280;  thi = 25600;  end
      REG_DEFAULT_ACCEL:   begin lo = 0;      hi = 65535;    tlo = 100;   thi = 5000;   end
      REG_CRUISE_SPEED:    begin lo = 0;      hi = 65535;    tlo = 50;    thi = 1000;   end
      REG_TICK_PERIOD:     begin lo = 0;      hi = 16777215; tlo = 1600;  thi = 170000; end
      REG_WHEEL_BIAS:      begin lo = -32768; hi = 32767;    tlo = -4096; thi = 4096;   end
      REG_SPEED_PER_RPM:   begin lo = 0;      hi = 16777215; tlo = 8192;  thi = 600000; end
      default:             begin lo = 0;      hi = 32767;    tlo = 800;   thi = 32767;  end
    endcase
    case (how)
      PICK_LOW:  v = lo;
      PICK_HIGH: v = hi;
      PICK_ANY:  v = lo + int'($urandom_range(0, hi - lo));
      default:   v = tlo + int'($urandom_range(0, thi - tlo));
    endcase
    return (idx == REG_WHEEL_BIAS) ? CFG_DATA_W'(v & 'hFFFF) : CFG_DATA_W'(v);
  endfunction

  // one register write; cfg_valid stays up so back-to-back writes need no idle gap
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_STOP_WINDOW:     model_cfg.stop_window     = val[15:0];
      REG_HALF_WHEEL_BASE: model_cfg.half_wheel_base = val[15:0];
      REG_DEFAULT_ACCEL:   model_cfg.default_accel   = val[15:0];
      REG_CRUISE_SPEED:    model_cfg.cruise_speed    = val[15:0];
      REG_TICK_PERIOD:     model_cfg.tick_period     = val[23:0];
      REG_WHEEL_BIAS:      model_cfg.wheel_bias      = val[15:0];
      REG_SPEED_PER_RPM:   model_cfg.speed_per_rpm   = val[23:0];
      REG_RPM_LIMIT:       model_cfg.rpm_limit       = val[14:0];
      default: ;
    endcase
  endtask

  // rewrite every register; only called with nothing in flight
  task automatic apply_setting(input pick_t mode);
    for (int i = 0; i < 8; i++)
      write_reg(CFG_IDX_W'(i),
                pick_value(CFG_IDX_W'(i), (mode == PICK_MIXED) ? pick_t'($urandom_range(0, 3))
                                                               : mode));
    cfg_valid <= 1'b0;
  endtask

  // one input transfer in bursts with random gaps, then the expected command is queued
  task automatic send_item(input logic op, input logic [IN_TDATA_W-1:0] d, input int known);
    wheel_cmd_t res;
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    res = next_wheel_command(op, d);
    if (op == OP_TICK)
      last_left = res.left_cmd;
    if (known != PREDICT)
      res = '{left_cmd: '0, right_cmd: '0, cmd_valid: known[0], turn_done: known[1]};
    pending_cmds.push_back(res);
  endtask

  // a start and a run of ticks that close in on the target, ending at or just past the window edge
  task automatic run_turn(inout int sent);
    longint      h, tgt, turn, win;
    int          n;
    logic [15:0] ml, mr, sp;
    h = longint'($signed(24'($urandom)));
    case ($urandom_range(0, 2))
      0:       turn = $urandom_range(0, 4 * model_cfg.stop_window + 16);
      1:       turn = $urandom_range(0, 1 << 18);
      default: turn = longint'($signed(24'($urandom)));
    endcase
    if ($urandom_range(0, 1))
      turn = -turn;
    send_item(OP_START, pack_in(24'(h), 24'(turn), 16'($urandom), 16'($urandom),
                                16'($urandom)), PREDICT);
    sent++;
    tgt = longint'($signed(24'(h + turn)));
    last_left = '0;
    n = $urandom_range(2, 14);
    for (int k = 0; k < n; k++) begin
      if (k >= n - 2) begin
        // settle at or just past the window edge with the wheels nearly still
        win = $urandom_range(0, model_cfg.stop_window + 1);
        h = $urandom_range(0, 1) ? tgt + win : tgt - win;
        ml = 16'(int'($urandom_range(0, 6)) - 3);
        mr = 16'(int'($urandom_range(0, 6)) - 3);
      end else begin
        h = h + ((tgt - h) >>> $urandom_range(1, 3));
        ml = last_left + 16'($urandom_range(0, 64)) - 16'd32;
        mr = -ml;
      end
      // usually the setpoint we were given last time, sometimes a disturbed one
      sp = ($urandom_range(0, 7) == 0) ? 16'($urandom) : last_left;
      send_item(OP_TICK, pack_in(24'(h), 24'($urandom), ml, mr, sp), PREDICT);
      sent++;
    end
  endtask

  task automatic compare_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: every output transfer must match the oldest pending command
  always @(posedge clk) begin
    wheel_cmd_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("result with no command pending: tdata %h tuser %b", out_tdata, out_tuser);
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        compare_field("left_command", $signed(want.left_cmd), $signed(out_tdata[15:0]));
        compare_field("right_command", $signed(want.right_cmd), $signed(out_tdata[31:16]));
        compare_field("command_valid", want.cmd_valid, out_tuser[0]);
        compare_field("turn_done", want.turn_done, out_tuser[1]);
      end
    end
  end

  // receiver stalls, only while ready_lazy is set: runs of random, mostly-ready and half-blocked patterns
  always @(posedge clk) begin
    pat_step <= pat_step + 1'b1;
    out_tready <= ready_pat[0] | !ready_lazy;
    if (pat_step == '1) begin
      case ($urandom_range(0, 3))
        0:       ready_pat <= '1;
        1:       ready_pat <= $urandom;
        2:       ready_pat <= $urandom | $urandom;
        default: ready_pat <= {16'h0000, 16'hFFFF};
      endcase
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[31:1]};
    end
  end

  // watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    probe_t probes[$];
    int     sent;
    model_cfg = '{stop_window: RST_STOP_WINDOW, half_wheel_base: RST_HALF_WHEEL_BASE,
                  default_accel: RST_DEFAULT_ACCEL, cruise_speed: RST_CRUISE_SPEED,
                  tick_period: RST_TICK_PERIOD, wheel_bias: RST_WHEEL_BIAS,
                  speed_per_rpm: RST_SPEED_PER_RPM, rpm_limit: RST_RPM_LIMIT};

    // directed table, run on the reset settings
    // fields: op, heading, turn_angle, meas left, meas right, left setpoint, check
    probes.push_back(probe(OP_TICK, 0, 0, 0, 0, 0, HOLD_DONE));     // target 0 after reset
    probes.push_back(probe(OP_TICK, 0, 0, 2, 0, 0, HOLD_MOVING));   // just above stop speed
    probes.push_back(probe(OP_TICK, 2048, 0, 1, -1, 0, HOLD_DONE)); // window edge, creeping
    probes.push_back(probe(OP_TICK, -2048, 0, 0, -32768, 0, HOLD_MOVING)); // right full reverse
    probes.push_back(probe(OP_TICK, 2049, 0, 0, 0, 0, PREDICT));    // one past the window
    probes.push_back(probe(OP_START, 0, 8388607, -1, -1, -1, ZERO_RESULT)); // largest turn
    probes.push_back(probe(OP_TICK, 0, 0, 0, 0, 0, PREDICT));       // accelerate from rest
    probes.push_back(probe(OP_TICK, 0, 0, 0, 0, 32767, PREDICT));   // full speed, long arc
    probes.push_back(probe(OP_TICK, 8385607, 0, 0, 0, 32767, PREDICT)); // short arc, hard brake
    probes.push_back(probe(OP_TICK, 0, 0, 0, 0, 3200, PREDICT));    // at cruise speed, hold
    probes.push_back(probe(OP_START, 8388607, 8388607, 0, 0, 0, ZERO_RESULT)); // target wraps
    probes.push_back(probe(OP_TICK, -8388608, 0, 0, 0, -32768, PREDICT)); // extreme heading
    probes.push_back(probe(OP_START, -8388608, -8388608, 0, 0, 0, ZERO_RESULT)); // wraps to 0
    probes.push_back(probe(OP_TICK, 8388607, 0, 32767, 32767, 32767, PREDICT));
    probes.push_back(probe(OP_START, 0, -100000, 0, 0, 0, ZERO_RESULT)); // negative turn
    probes.push_back(probe(OP_TICK, 0, 0, 0, 0, 100, PREDICT));     // turning the other way
    probes.push_back(probe(OP_TICK, -99000, 0, 1, 1, 0, HOLD_DONE)); // inside, creeping
    probes.push_back(probe(OP_TICK, -97951, 0, 0, 0, 50, PREDICT)); // one past the window
    probes.push_back(probe(OP_START, 5000, 0, 0, 0, 0, ZERO_RESULT)); // zero turn
    probes.push_back(probe(OP_TICK, 5000, -1, 32767, -32768, -1, HOLD_MOVING)); // wheels maxed

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i])
      send_item(probes[i].op, probes[i].d, probes[i].known);

    // random phases, each under its own register setting and idling pattern
    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        in_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_cmds.size() != 0) @(posedge clk);
        case (ph)
          1:       apply_setting(PICK_LOW);
          2:       apply_setting(PICK_HIGH);
          3, 4:    apply_setting(PICK_TYPICAL);
          default: apply_setting(PICK_MIXED);
        endcase
      end
      gap_max = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 6 : 160);
      ready_lazy <= (ph % 2 == 1);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: any op with every data bit random
          send_item(logic'($urandom_range(0, 1)), {$urandom, $urandom, $urandom}, PREDICT);
          sent++;
        end else begin
          run_turn(sent);
        end
      end
    end

    in_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
rtl/rtp_pkg.sv
rtl/rtp_regs.sv
rtl/rtp_mul.sv
rtl/rtp_div.sv
rtl/rotation_trapezoid_profiler.sv
rtl/rtp_checker.sv
bench/testbench.sv
